>>> sv/mstas_pkg.sv
package mstas_pkg;

    localparam logic [2:0] OP_ADD_COUNTDOWN = 3'd0;
    localparam logic [2:0] OP_ADD_ALARM     = 3'd1;
    localparam logic [2:0] OP_CANCEL        = 3'd2;
    localparam logic [2:0] OP_DISMISS       = 3'd3;
    localparam logic [2:0] OP_DISMISS_ALL   = 3'd4;
    localparam logic [2:0] OP_STEP          = 3'd5;
    localparam logic [2:0] OP_QUERY         = 3'd6;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_RANGE     = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_NO_CLOCK  = 3'd4;

    localparam logic [1:0] SLOT_FREE    = 2'd0;
    localparam logic [1:0] SLOT_PENDING = 2'd1;
    localparam logic [1:0] SLOT_RINGING = 2'd2;

    localparam logic [2:0] REG_MIN_SECONDS = 3'd0;
    localparam logic [2:0] REG_MAX_SECONDS = 3'd1;
    localparam logic [2:0] REG_CLOCK_VALID = 3'd2;
    localparam logic [2:0] REG_MISS_GRACE  = 3'd3;
    localparam logic [2:0] REG_RING        = 3'd4;

    localparam int MAX_REPORT = 8;
    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef struct packed {
        logic [2:0]  op;
        logic [19:0] seconds;
        logic [39:0] alarm_sec;
        logic [47:0] now_ms;
        logic [39:0] wall_sec;
        logic [31:0] target_id;
        logic [31:0] cap_ms;
        logic [3:0]  report_limit;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] timer_id;
        logic [3:0]  slot_count;
        logic [3:0]  ringing_count;
        logic [31:0] missed_count;
        logic [31:0] timeout_ms;
        logic        last;
    } out_t;

endpackage

>>> sv/multi_slot_timer_alarm_scheduler.sv
// Channel  | Signals                          | Direction | Moves
// ---------+----------------------------------+-----------+-------------------------
// in       | in_valid, in_ready, in_data      | into      | one operation word
// out      | out_valid, out_ready, out_data   | out of    | result words, last marks end
// cfg      | cfg_we, cfg_index, cfg_data      | into      | register write, no wait
//
// One word is accepted and passes a setup state, then walks the slot table one
// slot per cycle (query steps through phases on each slot, as the shared
// subtract and multiply are reused), then one result word per out_ready cycle.
// Add, cancel and dismiss stop at the first matching slot; range and clock
// rejects skip the walk. Reset frees all slots at once.
// in_ready is low from accept until the last result word is taken; a stalled
// out_ready holds the current result word.
module multi_slot_timer_alarm_scheduler #(
    parameter int SLOTS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mstas_pkg::in_t    in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output mstas_pkg::out_t   out_data,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [39:0]       cfg_data
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    // configuration
    logic [19:0] min_sec_reg;
    logic [19:0] max_sec_reg;
    logic [39:0] clk_valid_reg;
    logic [15:0] grace_reg;
    logic [15:0] ring_reg;

    // slot table
    logic [1:0]  slot_st_reg    [SLOTS];
    logic        slot_alarm_reg [SLOTS];
    logic [31:0] slot_id_reg    [SLOTS];
    logic [47:0] slot_due_reg   [SLOTS];
    logic [47:0] slot_rs_reg    [SLOTS];

    logic [31:0] next_id_reg, next_id_next;
    logic [31:0] missed_reg, missed_next;

    // sequencer
    logic [1:0]    state_reg, state_next;
    mstas_pkg::in_t item_reg;
    logic [IW-1:0] idx_reg, idx_next;
    logic [1:0]    phase_reg, phase_next;
    logic [29:0]   prod_reg;
    logic [25:0]   ring_ms_reg;
    logic [25:0]   grace_ms_reg;
    logic          clock_ok_reg;
    logic [48:0]   a_reg, a_next;
    logic [48:0]   r_reg, r_next;
    logic          use_reg, use_next;
    logic [31:0]   tmo_reg, tmo_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] ring_cnt_reg, ring_cnt_next;
    logic [3:0]    rep_reg, rep_next;
    logic [3:0]    emit_k_reg, emit_k_next;
    logic [31:0]   ids_reg [mstas_pkg::MAX_REPORT];
    logic [2:0]    res_status_reg, res_status_next;
    logic [31:0]   res_id_reg, res_id_next;

    // slot write controls
    logic          wr_st;
    logic [1:0]    wr_st_val;
    logic          wr_new;
    logic          wr_rs;
    logic          wr_ids;
    logic [47:0]   new_due;

    // current slot
    logic [1:0]    cur_st;
    logic          cur_alarm;
    logic [31:0]   cur_id;
    logic [47:0]   cur_due;
    logic [47:0]   cur_rs;
    logic          last_slot;
    logic [48:0]   due_sum;
    logic [3:0]    cap_rep;
    logic [47:0]   now_op;
    logic [47:0]   late;
    logic [47:0]   late_thr;
    logic          due_now;
    logic [47:0]   ring_age;
    logic [39:0]   alarm_left;
    logic [48:0]   ring_end;
    logic [32:0]   alarm_ms;
    logic          id_hit;
    logic [7:0]    cnt_wide;
    logic [7:0]    ring_wide;

    assign cur_st    = slot_st_reg[idx_reg];
    assign cur_alarm = slot_alarm_reg[idx_reg];
    assign cur_id    = slot_id_reg[idx_reg];
    assign cur_due   = slot_due_reg[idx_reg];
    assign cur_rs    = slot_rs_reg[idx_reg];
    assign last_slot = (idx_reg == IW'(SLOTS - 1));

    assign due_sum = {1'b0, item_reg.now_ms} + 49'(prod_reg);
    assign cap_rep = (item_reg.report_limit > 4'(mstas_pkg::MAX_REPORT))
                   ? 4'(mstas_pkg::MAX_REPORT) : item_reg.report_limit;

    // one shared lateness subtract for countdowns and alarms
    assign now_op   = cur_alarm ? {8'd0, item_reg.wall_sec} : item_reg.now_ms;
    assign late     = now_op - cur_due;
    assign late_thr = cur_alarm ? {32'd0, grace_reg} : {22'd0, grace_ms_reg};
    assign due_now  = cur_alarm ? (clock_ok_reg && (now_op >= cur_due))
                                : (now_op >= cur_due);
    assign ring_age = item_reg.now_ms - cur_rs;

    assign alarm_left = cur_due[39:0] - item_reg.wall_sec;
    assign ring_end   = 49'(cur_rs) + 49'(ring_ms_reg);
    assign alarm_ms   = 33'(a_reg[22:0]) * 33'(mstas_pkg::MS_PER_S);

    assign id_hit = (cur_st != mstas_pkg::SLOT_FREE) && (cur_id == item_reg.target_id)
                  && (item_reg.target_id != 32'd0);

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_EMIT);

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        phase_next      = phase_reg;
        a_next          = a_reg;
        r_next          = r_reg;
        use_next        = use_reg;
        tmo_next        = tmo_reg;
        cnt_next        = cnt_reg;
        ring_cnt_next   = ring_cnt_reg;
        rep_next        = rep_reg;
        emit_k_next     = emit_k_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        next_id_next    = next_id_reg;
        missed_next     = missed_reg;
        wr_st           = 1'b0;
        wr_st_val       = mstas_pkg::SLOT_FREE;
        wr_new          = 1'b0;
        wr_rs           = 1'b0;
        wr_ids          = 1'b0;
        new_due         = due_sum[48] ? 48'hFFFF_FFFF_FFFF : due_sum[47:0];
        if (item_reg.op == mstas_pkg::OP_ADD_ALARM)
        begin
            new_due = {8'd0, item_reg.alarm_sec};
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next    = S_PREP;
                    idx_next      = '0;
                    phase_next    = 2'd0;
                    cnt_next      = '0;
                    ring_cnt_next = '0;
                    rep_next      = 4'd0;
                    emit_k_next   = 4'd0;
                    tmo_next      = in_data.cap_ms;
                    res_id_next   = 32'd0;
                end
            end

            S_PREP:
            begin
                state_next      = S_SCAN;
                res_status_next = mstas_pkg::ST_OK;
                case (item_reg.op)
                    mstas_pkg::OP_ADD_COUNTDOWN:
                    begin
                        if ((item_reg.seconds < min_sec_reg)
                            || (item_reg.seconds > max_sec_reg))
                        begin
                            res_status_next = mstas_pkg::ST_RANGE;
                            state_next      = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_ADD_ALARM:
                    begin
                        if (item_reg.wall_sec < clk_valid_reg)
                        begin
                            res_status_next = mstas_pkg::ST_NO_CLOCK;
                            state_next      = S_EMIT;
                        end
                        else if (item_reg.alarm_sec <= item_reg.wall_sec)
                        begin
                            res_status_next = mstas_pkg::ST_RANGE;
                            state_next      = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_CANCEL, mstas_pkg::OP_DISMISS, mstas_pkg::OP_DISMISS_ALL,
                    mstas_pkg::OP_STEP, mstas_pkg::OP_QUERY:
                    begin
                        res_status_next = mstas_pkg::ST_OK;
                    end
                    default:
                    begin
                        res_status_next = mstas_pkg::ST_NOT_FOUND;
                        state_next      = S_EMIT;
                    end
                endcase
            end

            S_SCAN:
            begin
                case (item_reg.op)
                    mstas_pkg::OP_ADD_COUNTDOWN, mstas_pkg::OP_ADD_ALARM:
                    begin
                        if (cur_st == mstas_pkg::SLOT_FREE)
                        begin
                            wr_st        = 1'b1;
                            wr_st_val    = mstas_pkg::SLOT_PENDING;
                            wr_new       = 1'b1;
                            res_id_next  = next_id_reg;
                            next_id_next = (next_id_reg == 32'hFFFF_FFFF)
                                         ? 32'd1 : next_id_reg + 32'd1;
                            state_next   = S_EMIT;
                        end
                        else if (last_slot)
                        begin
                            res_status_next = mstas_pkg::ST_FULL;
                            state_next      = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_CANCEL:
                    begin
                        if (id_hit)
                        begin
                            wr_st      = 1'b1;
                            state_next = S_EMIT;
                        end
                        else if (last_slot)
                        begin
                            res_status_next = mstas_pkg::ST_NOT_FOUND;
                            state_next      = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_DISMISS:
                    begin
                        if (id_hit)
                        begin
                            state_next = S_EMIT;
                            if (cur_st == mstas_pkg::SLOT_RINGING)
                            begin
                                wr_st    = 1'b1;
                                cnt_next = CW'(1);
                            end
                            else
                            begin
                                res_status_next = mstas_pkg::ST_NOT_FOUND;
                            end
                        end
                        else if (last_slot)
                        begin
                            res_status_next = mstas_pkg::ST_NOT_FOUND;
                            state_next      = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_DISMISS_ALL:
                    begin
                        if (cur_st == mstas_pkg::SLOT_RINGING)
                        begin
                            wr_st    = 1'b1;
                            cnt_next = cnt_reg + CW'(1);
                        end
                        if (last_slot)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_STEP:
                    begin
                        if (cur_st == mstas_pkg::SLOT_RINGING)
                        begin
                            if ((item_reg.now_ms >= cur_rs)
                                && (ring_age >= 48'(ring_ms_reg)))
                            begin
                                wr_st = 1'b1;
                            end
                        end
                        else if ((cur_st == mstas_pkg::SLOT_PENDING) && due_now)
                        begin
                            wr_st = 1'b1;
                            if (late > late_thr)
                            begin
                                missed_next = missed_reg + 32'd1;
                            end
                            else
                            begin
                                wr_st_val = mstas_pkg::SLOT_RINGING;
                                wr_rs     = 1'b1;
                                cnt_next  = cnt_reg + CW'(1);
                                if (rep_reg < cap_rep)
                                begin
                                    wr_ids   = 1'b1;
                                    rep_next = rep_reg + 4'd1;
                                end
                            end
                        end
                        if (last_slot)
                        begin
                            state_next = S_EMIT;
                        end
                    end
                    mstas_pkg::OP_QUERY:
                    begin
                        case (phase_reg)
                            2'd0:
                            begin
                                phase_next = 2'd1;
                                use_next   = 1'b0;
                                if (cur_st != mstas_pkg::SLOT_FREE)
                                begin
                                    cnt_next = cnt_reg + CW'(1);
                                end
                                if (cur_st == mstas_pkg::SLOT_RINGING)
                                begin
                                    ring_cnt_next = ring_cnt_reg + CW'(1);
                                    use_next      = 1'b1;
                                    a_next        = ring_end;
                                end
                                else if ((cur_st == mstas_pkg::SLOT_PENDING) && !cur_alarm)
                                begin
                                    use_next = 1'b1;
                                    a_next   = 49'(cur_due);
                                end
                                else if ((cur_st == mstas_pkg::SLOT_PENDING) && clock_ok_reg)
                                begin
                                    use_next = 1'b1;
                                    // clamp: anything this far out exceeds any cap
                                    if (cur_due[39:0] <= item_reg.wall_sec)
                                    begin
                                        a_next = 49'd0;
                                    end
                                    else if (alarm_left[39:23] != 17'd0)
                                    begin
                                        a_next = 49'h7F_FFFF;
                                    end
                                    else
                                    begin
                                        a_next = 49'(alarm_left[22:0]);
                                    end
                                end
                            end
                            2'd1:
                            begin
                                phase_next = 2'd2;
                                if (cur_alarm && (cur_st == mstas_pkg::SLOT_PENDING))
                                begin
                                    r_next = 49'(alarm_ms);
                                end
                                else if (a_reg > {1'b0, item_reg.now_ms})
                                begin
                                    r_next = a_reg - {1'b0, item_reg.now_ms};
                                end
                                else
                                begin
                                    r_next = 49'd0;
                                end
                            end
                            default:
                            begin
                                phase_next = 2'd0;
                                if (use_reg && (r_reg < 49'(tmo_reg)))
                                begin
                                    tmo_next = r_reg[31:0];
                                end
                                if (last_slot)
                                begin
                                    state_next = S_EMIT;
                                end
                            end
                        endcase
                    end
                    default:
                    begin
                        state_next = S_EMIT;
                    end
                endcase
                if ((state_next == S_SCAN) && (phase_next == 2'd0) && !last_slot)
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            default:
            begin
                if (out_ready)
                begin
                    if (out_data.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        emit_k_next = emit_k_reg + 4'd1;
                    end
                end
            end
        endcase
    end

    // result word
    assign cnt_wide  = 8'(cnt_reg);
    assign ring_wide = 8'(ring_cnt_reg);

    always_comb
    begin
        out_data.status        = res_status_reg;
        out_data.timer_id      = res_id_reg;
        out_data.slot_count    = (cnt_wide > 8'd15) ? 4'd15 : cnt_wide[3:0];
        out_data.ringing_count = 4'd0;
        out_data.missed_count  = missed_reg;
        out_data.timeout_ms    = 32'd0;
        out_data.last          = 1'b1;
        if (item_reg.op == mstas_pkg::OP_QUERY)
        begin
            out_data.ringing_count = (ring_wide > 8'd15) ? 4'd15 : ring_wide[3:0];
            out_data.timeout_ms    = tmo_reg;
        end
        if ((item_reg.op == mstas_pkg::OP_STEP) && (emit_k_reg < rep_reg))
        begin
            out_data.timer_id = ids_reg[emit_k_reg[2:0]];
            out_data.last     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            phase_reg      <= 2'd0;
            cnt_reg        <= '0;
            ring_cnt_reg   <= '0;
            rep_reg        <= 4'd0;
            emit_k_reg     <= 4'd0;
            res_status_reg <= mstas_pkg::ST_OK;
            next_id_reg    <= 32'd1;
            missed_reg     <= 32'd0;
            min_sec_reg    <= 20'd1;
            max_sec_reg    <= 20'd86400;
            clk_valid_reg  <= 40'd1577836800;
            grace_reg      <= 16'd60;
            ring_reg       <= 16'd60;
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_st_reg[i] <= mstas_pkg::SLOT_FREE;
            end
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            phase_reg      <= phase_next;
            cnt_reg        <= cnt_next;
            ring_cnt_reg   <= ring_cnt_next;
            rep_reg        <= rep_next;
            emit_k_reg     <= emit_k_next;
            res_status_reg <= res_status_next;
            next_id_reg    <= next_id_next;
            missed_reg     <= missed_next;
            if (wr_st)
            begin
                slot_st_reg[idx_reg] <= wr_st_val;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    mstas_pkg::REG_MIN_SECONDS: min_sec_reg   <= cfg_data[19:0];
                    mstas_pkg::REG_MAX_SECONDS: max_sec_reg   <= cfg_data[19:0];
                    mstas_pkg::REG_CLOCK_VALID: clk_valid_reg <= cfg_data;
                    mstas_pkg::REG_MISS_GRACE:  grace_reg     <= cfg_data[15:0];
                    mstas_pkg::REG_RING:        ring_reg      <= cfg_data[15:0];
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_PREP)
        begin
            prod_reg     <= 30'(item_reg.seconds) * 30'(mstas_pkg::MS_PER_S);
            ring_ms_reg  <= 26'(ring_reg) * 26'(mstas_pkg::MS_PER_S);
            // integer seconds late exceed grace when ms late reach (grace+1)*1000
            grace_ms_reg <= 26'(grace_reg) * 26'(mstas_pkg::MS_PER_S) + 26'd999;
            clock_ok_reg <= (item_reg.wall_sec >= clk_valid_reg);
        end
        a_reg      <= a_next;
        r_reg      <= r_next;
        use_reg    <= use_next;
        tmo_reg    <= tmo_next;
        res_id_reg <= res_id_next;
        if (wr_new)
        begin
            slot_alarm_reg[idx_reg] <= (item_reg.op == mstas_pkg::OP_ADD_ALARM);
            slot_id_reg[idx_reg]    <= next_id_reg;
            slot_due_reg[idx_reg]   <= new_due;
        end
        if (wr_rs)
        begin
            slot_rs_reg[idx_reg] <= item_reg.now_ms;
        end
        if (wr_ids)
        begin
            ids_reg[rep_reg[2:0]] <= cur_id;
        end
    end

endmodule
